FILE: sv/fwsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsr_pkg
// shared types and codes of the fifo with search and remove
// ----------------------------------------------------------------------------
package fwsr_pkg;

	localparam int DATA_W   = 32;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int FILL_W   = 5;

	localparam logic [ACTION_W-1:0] ACT_PUSH   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_POP    = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_POP_WAIT,
		ST_SCAN,
		ST_SHIFT,
		ST_FINISH
	} fwsr_state_t;

endpackage

FILE: sv/fwsr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsr_ram
// simple dual port ram, one write port and one read port with registered read
// ----------------------------------------------------------------------------
module fwsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: sv/fifo_with_search_and_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_search_and_remove
// bounded queue of signed 32-bit values with push, pop, search and delete
// ----------------------------------------------------------------------------
// One request is worked on at a time; the result sits in an output register,
// so the next request is taken while an earlier result waits. Entries live
// in a ring held in one RAM with a single read port and a registered read.
// Search reads one entry per cycle from the newest end; delete then moves
// the newer entries down one slot to close the gap. The RAM needs no
// clearing after reset: only held entries are ever read.
// ----------------------------------------------------------------------------
module fifo_with_search_and_remove
	import fwsr_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [ACTION_W-1:0]        action,
	input  logic signed [DATA_W-1:0]   value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [STATUS_W-1:0]        status,
	output logic [POS_W-1:0]           position,
	output logic signed [DATA_W-1:0]   removed_value,
	output logic [FILL_W-1:0]          fill_level
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	fwsr_state_t state_q, state_nxt;

	logic [CW-1:0]       count_q;
	logic [AW-1:0]       oldest_q;
	logic [ACTION_W-1:0] act_q;
	logic [DATA_W-1:0]   val_q;
	logic [CW-1:0]       scan_q;
	logic [CW-1:0]       sh_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [POS_W-1:0]    res_pos_q;
	logic [DATA_W-1:0]   res_removed_q;
	logic                out_valid_q;

	logic              ram_wr_en;
	logic [AW-1:0]     ram_wr_addr;
	logic [DATA_W-1:0] ram_wr_data;
	logic              ram_rd_en;
	logic [AW-1:0]     ram_rd_addr;
	logic [DATA_W-1:0] ram_rd_data;

	logic          full;
	logic          empty;
	logic          hit;
	logic          scan_first;
	logic          hit_is_newest;
	logic          shift_last;
	logic          out_free;
	logic          in_accept;
	logic [CW-1:0] newest_idx;
	logic [CW:0]   sh_next2;

	function automatic logic [AW-1:0] ring_slot(input logic [CW-1:0] logical);
		logic [CW:0] sum;
		sum = {{(CW + 1 - AW){1'b0}}, oldest_q} + {1'b0, logical};
		if (sum >= (CW + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (CW + 1)'(QUEUE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign full          = (count_q == CW'(QUEUE_DEPTH));
	assign empty         = (count_q == '0);
	assign newest_idx    = count_q - CW'(1);
	assign hit           = (ram_rd_data == val_q);
	assign scan_first    = (scan_q == '0);
	assign hit_is_newest = (scan_q == newest_idx);
	assign sh_next2      = {1'b0, sh_q} + (CW + 1)'(2);
	assign shift_last    = (sh_next2 >= {1'b0, count_q});
	assign out_free      = !out_valid_q || !out_stall;
	assign in_accept     = in_valid && !in_stall;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_START;
				end
			end
			ST_START: begin
				if (act_q == ACT_PUSH) begin
					state_nxt = ST_FINISH;
				end else if (empty) begin
					state_nxt = ST_FINISH;
				end else if (act_q == ACT_POP) begin
					state_nxt = ST_POP_WAIT;
				end else begin
					state_nxt = ST_SCAN;
				end
			end
			ST_POP_WAIT: begin
				state_nxt = ST_FINISH;
			end
			ST_SCAN: begin
				if (hit) begin
					if (act_q == ACT_DELETE && !hit_is_newest) begin
						state_nxt = ST_SHIFT;
					end else begin
						state_nxt = ST_FINISH;
					end
				end else if (scan_first) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_SHIFT: begin
				if (shift_last) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// ram control and handshake
	always_comb begin
		in_stall    = 1'b1;
		ram_wr_en   = 1'b0;
		ram_wr_addr = ring_slot(count_q);
		ram_wr_data = val_q;
		ram_rd_en   = 1'b0;
		ram_rd_addr = oldest_q;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_START: begin
				if (act_q == ACT_PUSH) begin
					ram_wr_en = !full;
				end else if (act_q == ACT_POP) begin
					ram_rd_en = !empty;
				end else begin
					ram_rd_en   = !empty;
					ram_rd_addr = ring_slot(newest_idx);
				end
			end
			ST_SCAN: begin
				if (hit) begin
					ram_rd_en   = (act_q == ACT_DELETE) && !hit_is_newest;
					ram_rd_addr = ring_slot(scan_q + CW'(1));
				end else begin
					ram_rd_en   = !scan_first;
					ram_rd_addr = ring_slot(scan_q - CW'(1));
				end
			end
			ST_SHIFT: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = ring_slot(sh_q);
				ram_wr_data = ram_rd_data;
				ram_rd_en   = !shift_last;
				ram_rd_addr = ring_slot(sh_next2[CW-1:0]);
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			oldest_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_START: begin
					if (act_q == ACT_PUSH && !full) begin
						count_q <= count_q + CW'(1);
					end
				end
				ST_POP_WAIT: begin
					oldest_q <= (oldest_q == AW'(QUEUE_DEPTH - 1)) ? '0 : oldest_q + AW'(1);
					count_q  <= count_q - CW'(1);
				end
				ST_SCAN: begin
					if (hit && act_q == ACT_DELETE && hit_is_newest) begin
						count_q <= count_q - CW'(1);
					end
				end
				ST_SHIFT: begin
					if (shift_last) begin
						count_q <= count_q - CW'(1);
					end
				end
				default: begin
				end
			endcase
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			act_q <= action;
			val_q <= value;
		end
		case (state_q)
			ST_START: begin
				res_status_q  <= STAT_OK;
				res_pos_q     <= '0;
				res_removed_q <= '0;
				scan_q        <= newest_idx;
				if (act_q == ACT_PUSH) begin
					if (full) begin
						res_status_q <= STAT_FULL;
					end
				end else if (empty) begin
					res_status_q <= (act_q == ACT_POP) ? STAT_EMPTY : STAT_NOT_FOUND;
				end
			end
			ST_POP_WAIT: begin
				res_removed_q <= ram_rd_data;
			end
			ST_SCAN: begin
				if (hit) begin
					res_pos_q <= POS_W'(newest_idx - scan_q);
					sh_q      <= scan_q;
				end else if (scan_first) begin
					res_status_q <= STAT_NOT_FOUND;
				end else begin
					scan_q <= scan_q - CW'(1);
				end
			end
			ST_SHIFT: begin
				sh_q <= sh_q + CW'(1);
			end
			ST_FINISH: begin
				if (out_free) begin
					status        <= res_status_q;
					position      <= res_pos_q;
					removed_value <= res_removed_q;
					fill_level    <= FILL_W'(count_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

	fwsr_ram #(
		.WIDTH(DATA_W),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_oldest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oldest_q < AW'(QUEUE_DEPTH - 1) || oldest_q == AW'(QUEUE_DEPTH - 1))
		else $error("oldest slot outside the ring");

	a_scan_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_SHIFT || state_q == ST_POP_WAIT)
		|-> count_q != '0)
		else $error("scan or pop on an empty queue");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result posted outside finish");

	a_no_write_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_wr_en && ram_rd_en) |-> ram_wr_addr != ram_rd_addr)
		else $error("read and write of the same entry in one cycle");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the fifo with search and remove: a directed table
// covers empty, full, extreme values, duplicates and misses, then random
// request mixes under varying sender and receiver idling are checked against
// a queue-based predictor
// ----------------------------------------------------------------------------
module testbench;
	import fwsr_pkg::*;

	localparam int QUEUE_DEPTH   = 16;
	localparam int STALL_LIMIT   = 5000;
	localparam int DRAIN_CYCLES  = 60;
	localparam int RANDOM_PER_PH = 170;
	localparam int DIRECTED_ROWS = 18;

	localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7fff_ffff;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] removed;
		logic [FILL_W-1:0]        fill;
	} outcome_t;

	typedef struct packed {
		logic [ACTION_W-1:0]      act;
		logic signed [DATA_W-1:0] val;
		logic [4:0]               reps;
		logic                     typed;
		outcome_t                 want;
	} stim_row_t;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [ACTION_W-1:0]      action = ACT_PUSH;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [STATUS_W-1:0]      status;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] removed_value;
	logic [FILL_W-1:0]        fill_level;

	logic signed [DATA_W-1:0] held[$];
	outcome_t                 pending_outcomes[$];
	int                       failures = 0;
	int                       in_idle_pct = 0;
	int                       out_idle_pct = 0;
	int                       quiet_cycles = 0;

	stim_row_t directed [DIRECTED_ROWS] = '{
		'{ACT_POP,    32'sd0,    5'd1,  1'b1, '{STAT_EMPTY,     4'd0, 32'sd0,  5'd0}},
		'{ACT_SEARCH, 32'sd5,    5'd1,  1'b1, '{STAT_NOT_FOUND, 4'd0, 32'sd0,  5'd0}},
		'{ACT_DELETE, 32'sd5,    5'd1,  1'b1, '{STAT_NOT_FOUND, 4'd0, 32'sd0,  5'd0}},
		'{ACT_PUSH,   MIN_VAL,   5'd1,  1'b1, '{STAT_OK,        4'd0, 32'sd0,  5'd1}},
		'{ACT_POP,    32'sd0,    5'd1,  1'b1, '{STAT_OK,        4'd0, MIN_VAL, 5'd0}},
		'{ACT_PUSH,   MAX_VAL,   5'd1,  1'b1, '{STAT_OK,        4'd0, 32'sd0,  5'd1}},
		'{ACT_PUSH,   MIN_VAL,   5'd1,  1'b1, '{STAT_OK,        4'd0, 32'sd0,  5'd2}},
		'{ACT_PUSH,   32'sd100,  5'd12, 1'b0, '0},
		'{ACT_PUSH,   MAX_VAL,   5'd1,  1'b1, '{STAT_OK,        4'd0, 32'sd0,  5'd15}},
		'{ACT_PUSH,   -32'sd1,   5'd1,  1'b1, '{STAT_OK,        4'd0, 32'sd0,  5'd16}},
		'{ACT_PUSH,   32'sd5,    5'd1,  1'b1, '{STAT_FULL,      4'd0, 32'sd0,  5'd16}},
		'{ACT_SEARCH, MAX_VAL,   5'd1,  1'b0, '0},
		'{ACT_SEARCH, MIN_VAL,   5'd1,  1'b0, '0},
		'{ACT_DELETE, MAX_VAL,   5'd1,  1'b0, '0},
		'{ACT_DELETE, -32'sd1,   5'd1,  1'b0, '0},
		'{ACT_DELETE, MAX_VAL,   5'd1,  1'b0, '0},
		'{ACT_SEARCH, 32'sd999,  5'd1,  1'b1, '{STAT_NOT_FOUND, 4'd0, 32'sd0,  5'd13}},
		'{ACT_POP,    32'sd0,    5'd1,  1'b0, '0}
	};

	fifo_with_search_and_remove #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.position(position),
		.removed_value(removed_value),
		.fill_level(fill_level)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// newest entry sits at the back of held
	function automatic outcome_t queue_action_outcome(input logic [ACTION_W-1:0] act,
			input logic signed [DATA_W-1:0] val);
		outcome_t o;
		int hit;
		o = '0;
		hit = -1;
		if (act == ACT_SEARCH || act == ACT_DELETE) begin
			for (int p = held.size() - 1; p >= 0 && hit < 0; p--) begin
				if (held[p] == val) begin
					hit = p;
				end
			end
		end
		case (act)
			ACT_PUSH: begin
				if (held.size() >= QUEUE_DEPTH) begin
					o.status = STAT_FULL;
				end else begin
					held.push_back(val);
				end
			end
			ACT_POP: begin
				if (held.size() == 0) begin
					o.status = STAT_EMPTY;
				end else begin
					o.removed = held.pop_front();
				end
			end
			ACT_SEARCH: begin
				if (hit < 0) begin
					o.status = STAT_NOT_FOUND;
				end else begin
					o.position = POS_W'(held.size() - 1 - hit);
				end
			end
			ACT_DELETE: begin
				if (hit < 0) begin
					o.status = STAT_NOT_FOUND;
				end else begin
					o.position = POS_W'(held.size() - 1 - hit);
					held.delete(hit);
				end
			end
		endcase
		o.fill = FILL_W'(held.size());
		return o;
	endfunction

	// mostly values already held or a small pool, so hits and duplicates are common
	function automatic logic signed [DATA_W-1:0] pick_value();
		int sel;
		sel = $urandom_range(0, 99);
		if (held.size() > 0 && sel < 45) begin
			return held[$urandom_range(0, held.size() - 1)];
		end
		if (sel < 75) begin
			return DATA_W'(int'($urandom_range(0, 7)) - 4);
		end
		if (sel < 85) begin
			case ($urandom_range(0, 3))
				0: return MIN_VAL;
				1: return MAX_VAL;
				2: return '0;
				default: return -32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	task automatic send_request(input logic [ACTION_W-1:0] act,
			input logic signed [DATA_W-1:0] val, input logic typed, input outcome_t want);
		outcome_t predicted;
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		value    <= val;
		do @(posedge clk); while (in_stall);
		predicted = queue_action_outcome(act, val);
		pending_outcomes.push_back(typed ? want : predicted);
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < out_idle_pct);
	end

	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				$error("result with no request outstanding");
				failures++;
			end else begin
				want = pending_outcomes.pop_front();
				if (status !== want.status) begin
					$error("status expected %0d got %0d", want.status, status);
					failures++;
				end
				if (position !== want.position) begin
					$error("position expected %0d got %0d", want.position, position);
					failures++;
				end
				if (removed_value !== want.removed) begin
					$error("removed_value expected %0d got %0d", want.removed, removed_value);
					failures++;
				end
				if (fill_level !== want.fill) begin
					$error("fill_level expected %0d got %0d", want.fill, fill_level);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int mode;
		int roll;
		int push_w;
		int pop_w;
		int search_w;
		logic [ACTION_W-1:0] act;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		in_idle_pct  = 19;
		out_idle_pct = 73;
		foreach (directed[i]) begin
			for (int r = 0; r < directed[i].reps; r++) begin
				send_request(directed[i].act, directed[i].val + r, directed[i].typed,
					directed[i].want);
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			in_idle_pct  = (ph == 0) ? 19 : (ph == 1) ? 73 : 0;
			out_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 19 : 0;
			mode = 0;
			for (int n = 0; n < RANDOM_PER_PH; n++) begin
				// swing between filling, churning and draining
				if (n % 40 == 0) begin
					mode = $urandom_range(0, 2);
				end
				push_w   = (mode == 0) ? 55 : (mode == 1) ? 30 : 15;
				pop_w    = (mode == 0) ? 10 : (mode == 1) ? 25 : 35;
				search_w = (mode == 1) ? 25 : 20;
				roll = $urandom_range(0, 99);
				if (roll < push_w) begin
					act = ACT_PUSH;
				end else if (roll < push_w + pop_w) begin
					act = ACT_POP;
				end else if (roll < push_w + pop_w + search_w) begin
					act = ACT_SEARCH;
				end else begin
					act = ACT_DELETE;
				end
				send_request(act, pick_value(), 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
